// ----- hw/rtl/gri_pkg.sv -----
// Shared types, register codes and constants of the gyro rate integrator.
package gri_pkg;

	localparam int ACC_W   = 48;
	localparam int HALF_W  = ACC_W / 2;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// Configuration register indexes
	localparam logic [7:0] CFG_DATA_REGISTER = 8'd0;
	localparam logic [7:0] CFG_RATE_GAIN     = 8'd1;
	localparam logic [7:0] CFG_OUTPUT_GAIN   = 8'd2;
	localparam logic [7:0] CFG_HALF_RANGE    = 8'd3;

	// Register reset values
	localparam logic [7:0]  RST_DATA_REGISTER = 8'd1;
	localparam logic [31:0] RST_RATE_GAIN     = 32'd11439;
	localparam logic [15:0] RST_OUTPUT_GAIN   = 16'd300;
	localparam logic [14:0] RST_HALF_RANGE    = 15'd600;

	typedef struct packed {
		logic [7:0] first_reg;
		logic [7:0] byte_x_high;
		logic [7:0] byte_x_low;
		logic [7:0] byte_y_high;
		logic [7:0] byte_y_low;
		logic [7:0] byte_z_high;
		logic [7:0] byte_z_low;
	} sample_t;

	typedef struct packed {
		logic [15:0] match_x;
		logic [15:0] match_y;
		logic [15:0] match_z;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_D,
		ST_ACC,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_COMB,
		ST_FIN,
		ST_CLAMP,
		ST_DONE
	} state_t;

endpackage

// ----- hw/rtl/gri_if.sv -----
// Valid/ready channel interfaces for samples, results and configuration writes.
interface gri_sample_if;
	logic             valid;
	logic             ready;
	gri_pkg::sample_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gri_result_if;
	logic             valid;
	logic             ready;
	gri_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gri_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] value;

	modport source (output valid, output index, output value, input ready);
	modport sink   (input valid, input index, input value, output ready);
endinterface

// ----- hw/rtl/gri_mul.sv -----
// Shared signed multiplier of the integrator datapath.
module gri_mul (
	input  logic signed [gri_pkg::MUL_A_W-1:0] a,
	input  logic signed [gri_pkg::MUL_B_W-1:0] b,
	output logic signed [gri_pkg::MUL_P_W-1:0] p
);

	assign p = gri_pkg::MUL_P_W'(a) * gri_pkg::MUL_P_W'(b);

endmodule

// ----- hw/rtl/gyro_rate_integrator_to_pwm_unit.sv -----
// Top level: gyro rate integrator producing three PWM match values per record.
// A matching record is accepted in idle and then takes seven steps per axis
// on the one shared 33x18 multiplier and its adders, three axes in turn; the
// unit then waits until the output register is free and loads it. It takes
// the next record only after that, back in idle, never while one is in work.
// A record with another address is taken in idle and dropped.
// Reset (arst_n low) clears angles and previous rates and restores registers.
module gyro_rate_integrator_to_pwm_unit (
	input logic              clk,
	input logic              arst_n,
	gri_sample_if.sink       sample,
	gri_result_if.source     result,
	gri_cfg_if.sink          cfg
);

	localparam int W   = gri_pkg::ACC_W;
	localparam int HW  = gri_pkg::HALF_W;
	localparam int AW  = gri_pkg::MUL_A_W;
	localparam int BW  = gri_pkg::MUL_B_W;
	localparam int PW  = gri_pkg::MUL_P_W;

	// Configuration registers
	logic [7:0]  data_reg_q;
	logic [31:0] rate_gain_q;
	logic [15:0] output_gain_q;
	logic [14:0] half_range_q;

	// Per-axis state
	logic signed [W-1:0]  angle_q [3];
	logic signed [15:0]   prev_q  [3];

	// Working registers
	gri_pkg::state_t      state_q, state_d;
	logic [1:0]           ax_q;
	logic signed [15:0]   rate_q  [3];
	logic signed [PW-1:0] prod_q;
	logic [39:0]          lo_q;
	logic signed [W-1:0]  acc_q;
	logic signed [63:0]   full_q;
	logic signed [31:0]   scaled_q;
	logic [15:0]          match_q [3];

	logic                 out_valid_q;
	gri_pkg::result_t     out_q;

	// Shared multiplier operands
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;

	logic                 take_sample;
	logic                 hit;
	logic                 out_free;
	logic signed [16:0]   rate_sum;
	logic signed [PW-1:0] acc_sum;
	logic                 acc_fits;
	logic signed [W-1:0]  acc_sat;
	logic signed [63:0]   full_biased;
	logic signed [32:0]   s33;
	logic signed [32:0]   hr33;
	logic signed [32:0]   clamped;
	logic signed [32:0]   match_sum;

	gri_mul u_mul (
		.a (mul_a),
		.b (mul_b),
		.p (mul_p)
	);

	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign take_sample = sample.valid && sample.ready;
	assign hit         = (sample.data.first_reg == data_reg_q);
	assign out_free    = !out_valid_q || result.ready;

	// Trapezoid sum of previous and new raw rate
	assign rate_sum = 17'(prev_q[ax_q]) + 17'(rate_q[ax_q]);

	// Accumulate and saturate to the 48-bit angle range
	assign acc_sum  = PW'(angle_q[ax_q]) + prod_q;
	assign acc_fits = (acc_sum[PW-1:W-1] == {(PW-W+1){1'b0}}) ||
	                  (acc_sum[PW-1:W-1] == {(PW-W+1){1'b1}});
	always_comb begin
		if (acc_fits) begin
			acc_sat = acc_sum[W-1:0];
		end else if (acc_sum[PW-1]) begin
			acc_sat = gri_pkg::ACC_MIN;
		end else begin
			acc_sat = gri_pkg::ACC_MAX;
		end
	end

	// Bias negative values so the arithmetic shift truncates toward zero
	assign full_biased = full_q + (full_q[63] ? 64'sh0000_0000_FFFF_FFFF : 64'sh0);

	// Clamp about zero and offset by the PWM center
	assign s33  = 33'(scaled_q);
	assign hr33 = {18'b0, half_range_q};
	always_comb begin
		if (s33 > hr33) begin
			clamped = hr33 - 33'sd1;
		end else if (s33 < -hr33) begin
			clamped = 33'sd1 - hr33;
		end else begin
			clamped = s33;
		end
	end
	assign match_sum = hr33 + clamped;

	// Sequencer: next state, ready and multiplier operand selection
	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		case (state_q)
			gri_pkg::ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid && hit) begin
					state_d = gri_pkg::ST_MUL_D;
				end
			end
			gri_pkg::ST_MUL_D: begin
				mul_a   = {1'b0, rate_gain_q};
				mul_b   = BW'(rate_sum);
				state_d = gri_pkg::ST_ACC;
			end
			gri_pkg::ST_ACC: begin
				state_d = gri_pkg::ST_MUL_LO;
			end
			gri_pkg::ST_MUL_LO: begin
				mul_a   = {{(AW-HW){1'b0}}, acc_q[HW-1:0]};
				mul_b   = {2'b0, output_gain_q};
				state_d = gri_pkg::ST_MUL_HI;
			end
			gri_pkg::ST_MUL_HI: begin
				mul_a   = {{(AW-HW){acc_q[W-1]}}, acc_q[W-1:HW]};
				mul_b   = {2'b0, output_gain_q};
				state_d = gri_pkg::ST_COMB;
			end
			gri_pkg::ST_COMB: begin
				state_d = gri_pkg::ST_FIN;
			end
			gri_pkg::ST_FIN: begin
				state_d = gri_pkg::ST_CLAMP;
			end
			gri_pkg::ST_CLAMP: begin
				state_d = (ax_q == 2'd2) ? gri_pkg::ST_DONE : gri_pkg::ST_MUL_D;
			end
			gri_pkg::ST_DONE: begin
				// Hold until the output register is free
				if (out_free) begin
					state_d = gri_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gri_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state, configuration and per-axis state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gri_pkg::ST_IDLE;
			ax_q          <= 2'd0;
			out_valid_q   <= 1'b0;
			data_reg_q    <= gri_pkg::RST_DATA_REGISTER;
			rate_gain_q   <= gri_pkg::RST_RATE_GAIN;
			output_gain_q <= gri_pkg::RST_OUTPUT_GAIN;
			half_range_q  <= gri_pkg::RST_HALF_RANGE;
			for (int i = 0; i < 3; i++) begin
				angle_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg.valid) begin
				case (cfg.index)
					gri_pkg::CFG_DATA_REGISTER: data_reg_q    <= cfg.value[7:0];
					gri_pkg::CFG_RATE_GAIN:     rate_gain_q   <= cfg.value;
					gri_pkg::CFG_OUTPUT_GAIN:   output_gain_q <= cfg.value[15:0];
					gri_pkg::CFG_HALF_RANGE:    half_range_q  <= cfg.value[14:0];
					default: ;
				endcase
			end

			if (take_sample && hit) begin
				ax_q <= 2'd0;
			end else if (state_q == gri_pkg::ST_CLAMP) begin
				ax_q <= ax_q + 2'd1;
			end

			// Commit the saturated angle and advance the previous rate
			if (state_q == gri_pkg::ST_ACC) begin
				angle_q[ax_q] <= acc_sat;
				prev_q[ax_q]  <= rate_q[ax_q];
			end

			if (state_q == gri_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (take_sample) begin
			rate_q[0] <= {sample.data.byte_x_high, sample.data.byte_x_low};
			rate_q[1] <= {sample.data.byte_y_high, sample.data.byte_y_low};
			rate_q[2] <= {sample.data.byte_z_high, sample.data.byte_z_low};
		end
		case (state_q)
			gri_pkg::ST_MUL_D: begin
				prod_q <= mul_p;
			end
			gri_pkg::ST_ACC: begin
				acc_q <= acc_sat;
			end
			gri_pkg::ST_MUL_LO: begin
				prod_q <= mul_p;
			end
			gri_pkg::ST_MUL_HI: begin
				lo_q   <= prod_q[39:0];
				prod_q <= mul_p;
			end
			gri_pkg::ST_COMB: begin
				// Recombine high and low halves of angle times gain
				full_q <= {prod_q[39:0], {HW{1'b0}}} + {{HW{1'b0}}, lo_q};
			end
			gri_pkg::ST_FIN: begin
				scaled_q <= full_biased[63:32];
			end
			gri_pkg::ST_CLAMP: begin
				match_q[ax_q] <= match_sum[15:0];
			end
			gri_pkg::ST_DONE: begin
				if (out_free) begin
					out_q.match_x <= match_q[0];
					out_q.match_y <= match_q[1];
					out_q.match_z <= match_q[2];
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- dv/gyro_rate_integrator_to_pwm_unit_test.sv -----
// Self-checking testbench for the gyro rate integrator PWM unit.
`timescale 1ns / 1ps

module gyro_rate_integrator_to_pwm_unit_test;

	// Cycles with no beat on any channel before the run is declared hung.
	// The slowest legal gap is a whole record plus a long random stall.
	localparam int STALL_LIMIT   = 2000;
	// Quiet cycles after the last result before touching the registers.
	localparam int DRAIN_CYCLES  = 30;
	localparam int RAND_PHASES   = 12;
	localparam int PHASE_RECORDS = 85;
	// One angle unit in the Q16.32 accumulator.
	localparam longint ANGLE_ONE = 64'sd4294967296;

	// Tracks the integrated angles and the expected PWM match values.
	class pwm_match_scoreboard;
		logic [7:0]  sample_addr;
		logic [31:0] deg_per_lsb;
		logic [15:0] counts_per_deg;
		logic [14:0] pwm_center;
		longint      angle_q32[3];
		longint      last_raw[3];
		gri_pkg::result_t pending_matches[$];
		int unsigned records_seen, records_ignored, results_checked, mismatches;

		function new();
			sample_addr    = gri_pkg::RST_DATA_REGISTER;
			deg_per_lsb    = gri_pkg::RST_RATE_GAIN;
			counts_per_deg = gri_pkg::RST_OUTPUT_GAIN;
			pwm_center     = gri_pkg::RST_HALF_RANGE;
			for (int i = 0; i < 3; i++) begin
				angle_q32[i] = 0;
				last_raw[i]  = 0;
			end
		endfunction

		// Mirror one register write; unknown indexes are dropped.
		function void apply_write(logic [7:0] idx, logic [31:0] val);
			case (idx)
				gri_pkg::CFG_DATA_REGISTER: sample_addr    = val[7:0];
				gri_pkg::CFG_RATE_GAIN:     deg_per_lsb    = val;
				gri_pkg::CFG_OUTPUT_GAIN:   counts_per_deg = val[15:0];
				gri_pkg::CFG_HALF_RANGE:    pwm_center     = val[14:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] integrate_axis(int axis, logic [15:0] raw);
			longint rate, gain, og, hr, acc, scaled;
			rate = longint'($signed(raw));
			gain = longint'(deg_per_lsb);
			og   = longint'(counts_per_deg);
			hr   = longint'(pwm_center);
			// Trapezoid step, then hold at the accumulator limits.
			acc = angle_q32[axis] + (last_raw[axis] + rate) * gain;
			if (acc > longint'(gri_pkg::ACC_MAX))
				acc = longint'(gri_pkg::ACC_MAX);
			else if (acc < longint'(gri_pkg::ACC_MIN))
				acc = longint'(gri_pkg::ACC_MIN);
			angle_q32[axis] = acc;
			last_raw[axis]  = rate;
			// Signed division truncates toward zero.
			scaled = (acc * og) / ANGLE_ONE;
			if (scaled > hr)
				scaled = hr - 1;
			else if (scaled < -hr)
				scaled = -(hr - 1);
			return 16'(hr + scaled);
		endfunction

		function void take_sample(gri_pkg::sample_t rec);
			gri_pkg::result_t want;
			records_seen++;
			if (rec.first_reg != sample_addr) begin
				records_ignored++;
				return;
			end
			want.match_x = integrate_axis(0, {rec.byte_x_high, rec.byte_x_low});
			want.match_y = integrate_axis(1, {rec.byte_y_high, rec.byte_y_low});
			want.match_z = integrate_axis(2, {rec.byte_z_high, rec.byte_z_low});
			pending_matches.push_back(want);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_match(gri_pkg::result_t got);
			gri_pkg::result_t want;
			if (pending_matches.size() == 0) begin
				$error("unexpected result beat: match_x=%0d match_y=%0d match_z=%0d",
					got.match_x, got.match_y, got.match_z);
				mismatches++;
				return;
			end
			want = pending_matches.pop_front();
			results_checked++;
			compare_field("match_x", want.match_x, got.match_x);
			compare_field("match_y", want.match_y, got.match_y);
			compare_field("match_z", want.match_z, got.match_z);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gri_sample_if sample_ch ();
	gri_result_if result_ch ();
	gri_cfg_if    cfg_ch ();

	pwm_match_scoreboard board = new();

	int send_idle_pct = 38;
	int recv_idle_pct = 58;
	int quiet_cycles  = 0;
	int reg_writes    = 0;
	int settings_used = 0;

	gyro_rate_integrator_to_pwm_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Result side: check every accepted beat, then pick the next ready level.
	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			board.check_match(result_ch.data);
		result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: restart the count on any beat, bail out once it runs dry.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$error("no beat on any channel for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Hold a register write until the port takes it; valid stays high so
	// back-to-back writes need no second assignment in one step.
	task automatic cfg_write(input logic [7:0] idx, input logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.value <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		board.apply_write(idx, val);
		reg_writes++;
	endtask

	// Write all four registers, with junk above the narrower fields, optionally followed
	// by a write to an index past the register list.
	task automatic set_regs(input logic [7:0] addr, input logic [31:0] rg,
		input logic [15:0] og, input logic [14:0] hr, input bit stray);
		cfg_write(gri_pkg::CFG_DATA_REGISTER, {24'($urandom), addr});
		cfg_write(gri_pkg::CFG_RATE_GAIN, rg);
		cfg_write(gri_pkg::CFG_OUTPUT_GAIN, {16'($urandom), og});
		cfg_write(gri_pkg::CFG_HALF_RANGE, {17'($urandom), hr});
		if (stray)
			cfg_write(gri_pkg::CFG_HALF_RANGE + 8'd1 + 8'($urandom_range(0, 251)),
				$urandom);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// Offer one read record, idling first at the current sender rate.
	task automatic send_record(input logic [7:0] addr, input logic [15:0] rx,
		input logic [15:0] ry, input logic [15:0] rz);
		gri_pkg::sample_t rec;
		rec = {addr, rx, ry, rz};
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data  <= rec;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		board.take_sample(rec);
	endtask

	// Drop valid, wait for every pending match, then let the pipe go quiet.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (board.pending_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Mix of full-scale noise, small drift, mid values, the rail codes and the codes around zero.
	function automatic logic [15:0] random_rate();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return 16'($urandom);
		if (pick < 70)
			return 16'($urandom_range(0, 127) - 64);
		if (pick < 85)
			return 16'($urandom_range(0, 8191) - 4096);
		case ($urandom_range(3))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	initial begin
		logic [7:0]  addr, dreg;
		logic [31:0] rg;
		logic [15:0] og;
		logic [14:0] hr;
		int          taken;

		arst_n          = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.value    = '0;
		result_ch.ready = 1'b0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: only address one is processed; a zero record sits at center.
		send_record(8'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_record(8'h02, 16'h8000, 16'h8000, 16'h8000);
		send_record(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_record(8'h01, 16'h0000, 16'h0000, 16'h0000);
		settle();

		// One angle unit per 64 summed LSBs, unit output gain: x lands exactly
		// on +center, y exactly on -center, z just past it, then both clamp.
		set_regs(8'd1, 32'h0400_0000, 16'd1, 15'd600, 1'b0);
		send_record(8'h01, 16'd19200, -16'sd19200, 16'd19300);
		send_record(8'h01, 16'h0000, 16'h0000, 16'h0000);
		send_record(8'h01, 16'h8000, 16'h8000, 16'h8000);
		send_record(8'h01, 16'h8000, 16'h8000, 16'h8000);
		settle();

		// Zero center: the bits above the field are dropped, leaving zero, so the
		// match value wraps.
		cfg_write(gri_pkg::CFG_HALF_RANGE, 32'h0001_8000);
		cfg_ch.valid <= 1'b0;
		settings_used++;
		send_record(8'h01, 16'h7FFF, 16'h0000, 16'h0000);
		send_record(8'h01, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		settle();

		// Largest gains: drive the accumulators into both rails.
		set_regs(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 15'h7FFF, 1'b0);
		repeat (3)
			send_record(8'hFF, 16'h7FFF, 16'h8000, 16'h7FFF);
		repeat (3)
			send_record(8'hFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_record(8'h01, 16'h1234, 16'h5678, 16'h9ABC);
		settle();

		// Back to reset values, with a stray write past the register list.
		set_regs(gri_pkg::RST_DATA_REGISTER, gri_pkg::RST_RATE_GAIN,
			gri_pkg::RST_OUTPUT_GAIN, gri_pkg::RST_HALF_RANGE, 1'b1);
		send_record(8'h01, 16'h7FFF, 16'h8000, 16'h0000);
		send_record(8'h01, 16'hFFFF, 16'h0001, 16'h7FFF);
		send_record(8'h01, 16'h8000, 16'h7FFF, 16'h8000);
		settle();

		// Random phases: each picks a register setting, extremes among them,
		// and streams records; mostly matching, some with stray addresses.
		for (int k = 0; k < RAND_PHASES; k++) begin
			send_idle_pct = (k < 4) ? 38 : (k < 8) ? 58 : 0;
			recv_idle_pct = (k < 4) ? 58 : (k < 8) ? 38 : 0;

			case (k % 4)
				0:       dreg = 8'h00;
				1:       dreg = 8'hFF;
				default: dreg = 8'($urandom);
			endcase
			case (k % 4)
				0:       rg = $urandom_range(0, 65535);
				1:       rg = $urandom;
				2:       rg = $urandom_range(32'h0001_0000, 32'h0100_0000);
				default: rg = (k == 3) ? 32'd0 : 32'hFFFF_FFFF;
			endcase
			case (k % 3)
				0:       og = 16'($urandom_range(0, 1023));
				1:       og = 16'($urandom_range(0, 65535));
				default: og = (k == 2) ? 16'd0 : 16'hFFFF;
			endcase
			case (k % 5)
				0:       hr = 15'($urandom_range(1, 1000));
				1:       hr = 15'h7FFF;
				2:       hr = 15'd1;
				3:       hr = 15'($urandom_range(1, 32767));
				default: hr = 15'($urandom_range(0, 100));
			endcase
			set_regs(dreg, rg, og, hr, (k % 4) == 1);

			taken = 0;
			while (taken < PHASE_RECORDS) begin
				addr = ($urandom_range(99) < 15) ? 8'($urandom) : dreg;
				if (addr == dreg)
					taken++;
				send_record(addr, random_rate(), random_rate(), random_rate());
			end
			settle();
		end

		if (board.pending_matches.size() != 0) begin
			$error("%0d expected results never arrived", board.pending_matches.size());
			board.mismatches++;
		end

		$display("Covered %0d read records (%0d with other addresses) and checked %0d results,",
			board.records_seen, board.records_ignored, board.results_checked);
		$display("over %0d register settings and %0d register writes.", settings_used, reg_writes);
		if (board.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/gri_pkg.sv
hw/rtl/gri_if.sv
hw/rtl/gri_mul.sv
hw/rtl/gyro_rate_integrator_to_pwm_unit.sv
dv/gyro_rate_integrator_to_pwm_unit_test.sv
